// File: hdl/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int READ_MAX     = 16;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

  // request kinds
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_BEGIN  = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_WRITE_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_READ_LENGTH   = 2'd2;

  // bus controller status codes
  localparam logic [7:0] SC_START      = 8'h08;
  localparam logic [7:0] SC_RESTART    = 8'h10;
  localparam logic [7:0] SC_SLAW_ACK   = 8'h18;
  localparam logic [7:0] SC_SLAW_NACK  = 8'h20;
  localparam logic [7:0] SC_DATA_ACK   = 8'h28;
  localparam logic [7:0] SC_DATA_NACK  = 8'h30;
  localparam logic [7:0] SC_ARB_LOST   = 8'h38;
  localparam logic [7:0] SC_SLAR_ACK   = 8'h40;
  localparam logic [7:0] SC_SLAR_NACK  = 8'h48;
  localparam logic [7:0] SC_RXDATA_ACK = 8'h50;
  localparam logic [7:0] SC_RXDATA_NAK = 8'h58;

  // transfer status values
  localparam logic [2:0] TS_IDLE    = 3'd0;
  localparam logic [2:0] TS_PENDING = 3'd1;
  localparam logic [2:0] TS_DONE    = 3'd2;
  localparam logic [2:0] TS_NACK    = 3'd3;
  localparam logic [2:0] TS_ERROR   = 3'd4;

  // ack control values
  localparam logic [1:0] ACK_KEEP = 2'd0;
  localparam logic [1:0] ACK_ACK  = 2'd1;
  localparam logic [1:0] ACK_NACK = 2'd2;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] write_index;
    logic [4:0] read_index;
    logic [4:0] load_pointer;
  } seq_state_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [4:0] write_length;
    logic [4:0] read_length;
  } seq_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       start_request;
    logic       stop_request;
    logic       clear_start;
    logic [1:0] ack_control;
    logic       clear_interrupt;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [3:0] rx_index;
    logic [2:0] transfer_status;
  } seq_result_t;

endpackage

// File: hdl/i2cms_action.sv
`timescale 1ns / 1ps

module i2cms_action (
  input  logic [1:0]            req_type,
  input  logic [7:0]            write_byte,
  input  logic [7:0]            status_code,
  input  logic [7:0]            rx_byte,
  input  i2cms_pkg::seq_cfg_t   cfg,
  input  i2cms_pkg::seq_state_t state,
  input  logic [7:0]            store_byte,
  output i2cms_pkg::seq_state_t state_next,
  output i2cms_pkg::store_wr_t  store_wr,
  output i2cms_pkg::seq_result_t result
);
  import i2cms_pkg::*;

  localparam logic [4:0] DEPTH5 = 5'(BUFFER_DEPTH);
  localparam logic [4:0] RMAX5  = 5'(READ_MAX);

  logic [4:0] eff_wlen;
  logic [4:0] eff_rlen;
  logic [4:0] rd_idx_after;

  assign eff_wlen = (cfg.write_length > DEPTH5) ? DEPTH5 : cfg.write_length;
  assign eff_rlen = (cfg.read_length > RMAX5) ? RMAX5 : cfg.read_length;

  always_comb begin
    state_next   = state;
    result       = '0;
    store_wr.we  = 1'b0;
    store_wr.addr = state.load_pointer[ADDR_W-1:0];
    store_wr.data = write_byte;
    rd_idx_after = state.read_index;

    case (req_type)
      REQ_LOAD: begin
        if (state.load_pointer < DEPTH5) begin
          store_wr.we = 1'b1;
          state_next.load_pointer = state.load_pointer + 5'd1;
        end
      end
      REQ_BEGIN: begin
        state_next.write_index  = '0;
        state_next.read_index   = '0;
        state_next.load_pointer = '0;
        state_next.status       = TS_IDLE;
        result.start_request    = 1'b1;
      end
      REQ_STATUS: begin
        case (status_code)
          SC_START: begin
            result.tx_valid        = 1'b1;
            result.tx_byte         = cfg.slave_address;
            result.clear_start     = 1'b1;
            result.clear_interrupt = 1'b1;
            state_next.status      = TS_PENDING;
          end
          SC_RESTART: begin
            result.tx_valid        = 1'b1;
            result.tx_byte         = cfg.slave_address | 8'h01;
            result.clear_start     = 1'b1;
            result.clear_interrupt = 1'b1;
          end
          SC_SLAW_ACK, SC_DATA_ACK: begin
            result.clear_interrupt = 1'b1;
            if (state.write_index < eff_wlen && state.write_index < DEPTH5) begin
              result.tx_valid        = 1'b1;
              result.tx_byte         = store_byte;
              state_next.write_index = state.write_index + 5'd1;
            end else if (eff_rlen != 5'd0) begin
              result.start_request = 1'b1;
            end else begin
              state_next.status   = TS_DONE;
              result.stop_request = 1'b1;
            end
          end
          SC_SLAW_NACK, SC_DATA_NACK, SC_SLAR_NACK: begin
            result.stop_request    = 1'b1;
            result.clear_interrupt = 1'b1;
            state_next.status      = TS_NACK;
          end
          SC_ARB_LOST: begin
            result.clear_interrupt = 1'b1;
            state_next.status      = TS_ERROR;
          end
          SC_SLAR_ACK: begin
            result.ack_control     = (eff_rlen == 5'd1) ? ACK_NACK : ACK_ACK;
            result.clear_interrupt = 1'b1;
          end
          SC_RXDATA_ACK, SC_RXDATA_NAK: begin
            result.clear_interrupt = 1'b1;
            if (state.read_index < eff_rlen) begin
              result.rx_valid = 1'b1;
              result.rx_data  = rx_byte;
              result.rx_index = state.read_index[3:0];
              rd_idx_after    = state.read_index + 5'd1;
            end
            state_next.read_index = rd_idx_after;
            if (status_code == SC_RXDATA_ACK) begin
              // ACK until every requested byte has been received, then NACK
              result.ack_control = (rd_idx_after < eff_rlen) ? ACK_ACK : ACK_NACK;
            end else begin
              state_next.status   = TS_DONE;
              result.stop_request = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    result.transfer_status = state_next.status;
  end

endmodule

// File: hdl/i2c_master_transfer_sequencer.sv
`timescale 1ns / 1ps

// I2C master write-then-read sequencer. Each accepted item (load byte, begin
// transfer, or controller status event) yields exactly one result item in the
// next cycle, holding the controller actions for that item and the transfer
// status after it. One item is taken every cycle unless in_stall holds it; the
// single result register is the only stage, so in_stall follows out_stall
// while a result is held. Write bytes live in a 16-entry byte buffer; the byte
// at the write index the next item will see is read ahead into a register, so
// it is ready on time. cfg_ready is always high; configure only while idle.
module i2c_master_transfer_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] write_byte,
  input  logic [7:0] status_code,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       start_request,
  output logic       stop_request,
  output logic       clear_start,
  output logic [1:0] ack_control,
  output logic       clear_interrupt,
  output logic       rx_valid,
  output logic [7:0] rx_data,
  output logic [3:0] rx_index,
  output logic [2:0] transfer_status
);
  import i2cms_pkg::*;

  seq_cfg_t          cfg;
  seq_state_t        state;
  seq_state_t        state_next;
  store_wr_t         store_wr;
  seq_result_t       result_next;
  seq_result_t       res;
  logic [7:0]        write_store [BUFFER_DEPTH];
  logic              in_fire;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        store_byte;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS: cfg.slave_address <= cfg_data;
        CFG_WRITE_LENGTH:  cfg.write_length  <= cfg_data[4:0];
        CFG_READ_LENGTH:   cfg.read_length   <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  i2cms_action u_action (
    .req_type    (req_type),
    .write_byte  (write_byte),
    .status_code (status_code),
    .rx_byte     (rx_byte),
    .cfg         (cfg),
    .state       (state),
    .store_byte  (store_byte),
    .state_next  (state_next),
    .store_wr    (store_wr),
    .result      (result_next)
  );

  // write index the state holds after this edge
  assign rd_addr = rst ? '0 :
                   in_fire ? state_next.write_index[ADDR_W-1:0] :
                             state.write_index[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (in_fire && store_wr.we) begin
      write_store[store_wr.addr] <= store_wr.data;
    end
    // a load into the entry being fetched is passed straight through
    if (in_fire && store_wr.we && store_wr.addr == rd_addr) begin
      store_byte <= store_wr.data;
    end else begin
      store_byte <= write_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= result_next;
    end
  end

  assign tx_valid        = res.tx_valid;
  assign tx_byte         = res.tx_byte;
  assign start_request   = res.start_request;
  assign stop_request    = res.stop_request;
  assign clear_start     = res.clear_start;
  assign ack_control     = res.ack_control;
  assign clear_interrupt = res.clear_interrupt;
  assign rx_valid        = res.rx_valid;
  assign rx_data         = res.rx_data;
  assign rx_index        = res.rx_index;
  assign transfer_status = res.transfer_status;

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    state.load_pointer <= 5'(BUFFER_DEPTH))
    else $error("load pointer past buffer end");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    state.read_index <= 5'(READ_MAX))
    else $error("read index past read limit");

  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted item gave no result");

  a_begin_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && req_type == REQ_BEGIN |=> start_request && transfer_status == TS_IDLE)
    else $error("begin item result wrong");

  a_status_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> transfer_status == state.status)
    else $error("result status differs from state");

endmodule
